FILE: design/fapcm_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fapcm_pkg
// Shared types and constants for the fixed-point to PCM frame converter.
// ----------------------------------------------------------------------------
package fapcm_pkg;

  localparam int FRAC_BITS_DEF = 28;
  localparam int SAMPLE_W      = 32;

  // configuration register indexes
  localparam logic [1:0] REG_SAMPLE_FORMAT   = 2'd0;
  localparam logic [1:0] REG_SOURCE_CHANNELS = 2'd1;
  localparam logic [1:0] REG_DEST_CHANNELS   = 2'd2;

  localparam logic [1:0] CH_MONO   = 2'd1;
  localparam logic [1:0] CH_STEREO = 2'd2;

  typedef enum logic [1:0] {
    FMT_U8  = 2'd0,
    FMT_S16 = 2'd1,
    FMT_S24 = 2'd2,
    FMT_S32 = 2'd3
  } fmt_t;

  typedef enum logic [1:0] {
    MODE_STEREO  = 2'd0,
    MODE_MONO    = 2'd1,
    MODE_UPMIX   = 2'd2,
    MODE_DOWNMIX = 2'd3
  } mode_t;

  typedef struct packed {
    mode_t mode;
    logic  last;
  } ctl_t;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] left_sample;
    logic signed [SAMPLE_W-1:0] right_sample;
    logic                       end_of_block;
  } in_word_t;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] first_out;
    logic signed [SAMPLE_W-1:0] second_out;
    logic [1:0]                 out_count;
    logic                       block_last;
  } out_word_t;

endpackage

FILE: design/fapcm_lane.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fapcm_lane
// One sample lane: round and clip, then shift to the selected PCM format.
// ----------------------------------------------------------------------------
module fapcm_lane #(
  parameter int FRAC_BITS = fapcm_pkg::FRAC_BITS_DEF
) (
  input  logic                                 clk,
  input  logic                                 en_clip,
  input  logic                                 en_pcm,
  input  fapcm_pkg::fmt_t                      fmt,
  input  logic signed [fapcm_pkg::SAMPLE_W-1:0] sample,
  output logic [fapcm_pkg::SAMPLE_W-1:0]       pcm
);
  import fapcm_pkg::*;

  // two guard bits so rounding and the clip compare never wrap
  localparam int SW  = SAMPLE_W + 2;
  localparam int CW  = FRAC_BITS + 1;
  localparam int SH8  = FRAC_BITS - 7;
  localparam int SH16 = FRAC_BITS - 15;
  localparam int SH24 = FRAC_BITS - 23;
  localparam int SH32 = SAMPLE_W - 1 - FRAC_BITS;
  localparam logic signed [SW-1:0] ONE   = SW'(64'd1 << FRAC_BITS);
  localparam logic signed [SW-1:0] RND8  = SW'(64'd1 << (FRAC_BITS - 8));
  localparam logic signed [SW-1:0] RND16 = SW'(64'd1 << (FRAC_BITS - 16));
  localparam logic signed [SW-1:0] RND24 = SW'(64'd1 << (FRAC_BITS - 24));

  logic signed [SW-1:0] rnd;
  logic signed [SW-1:0] sum;
  logic signed [CW-1:0] clip_next;
  logic signed [CW-1:0] clip;
  logic signed [CW-1:0] sh8;
  logic signed [CW-1:0] sh16;
  logic signed [CW-1:0] sh24;
  logic [SAMPLE_W-1:0]  pcm_next;

  always_comb begin
    case (fmt)
      FMT_U8:  rnd = RND8;
      FMT_S16: rnd = RND16;
      FMT_S24: rnd = RND24;
      default: rnd = '0;
    endcase
    sum = SW'(sample) + rnd;
    if (sum >= ONE) begin
      clip_next = CW'(ONE - SW'(1));
    end else if (sum < -ONE) begin
      clip_next = CW'(-ONE);
    end else begin
      clip_next = CW'(sum);
    end
  end

  always_ff @(posedge clk) begin
    if (en_clip) begin
      clip <= clip_next;
    end
  end

  always_comb begin
    sh8  = clip >>> SH8;
    sh16 = clip >>> SH16;
    sh24 = clip >>> SH24;
    case (fmt)
      // adding 128 to an 8 bit signed value flips its top bit
      FMT_U8:  pcm_next = {{(SAMPLE_W-8){1'b0}}, ~sh8[7], sh8[6:0]};
      FMT_S16: pcm_next = {{(SAMPLE_W-16){sh16[15]}}, sh16[15:0]};
      FMT_S24: pcm_next = {{(SAMPLE_W-24){sh24[23]}}, sh24[23:0]};
      default: pcm_next = SAMPLE_W'(clip) << SH32;
    endcase
  end

  always_ff @(posedge clk) begin
    if (en_pcm) begin
      pcm <= pcm_next;
    end
  end

endmodule

FILE: design/fapcm_merge.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fapcm_merge
// Combines the two lane results into one output word and holds it.
// ----------------------------------------------------------------------------
module fapcm_merge (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           lane_valid,
  input  fapcm_pkg::ctl_t                ctl,
  input  logic [fapcm_pkg::SAMPLE_W-1:0] pcm0,
  input  logic [fapcm_pkg::SAMPLE_W-1:0] pcm1,
  output logic                           lane_ready,
  output logic                           out_valid,
  input  logic                           out_ready,
  output fapcm_pkg::out_word_t           out_word
);
  import fapcm_pkg::*;

  logic      two;
  out_word_t word_next;

  assign lane_ready = !out_valid || out_ready;

  always_comb begin
    two = (ctl.mode == MODE_STEREO) || (ctl.mode == MODE_UPMIX);
    word_next.first_out  = pcm0;
    word_next.second_out = two ? pcm1 : '0;
    word_next.out_count  = two ? 2'd2 : 2'd1;
    word_next.block_last = ctl.last;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (lane_ready) begin
      out_valid <= lane_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (lane_ready && lane_valid) begin
      out_word <= word_next;
    end
  end

endmodule

FILE: design/fixed_audio_to_pcm_mixer_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fixed_audio_to_pcm_mixer_unit
// Converts stereo fixed-point frames to PCM words with channel mixing.
// ----------------------------------------------------------------------------
// Usage:
//   in_word carries one frame (left, right, end_of_block) on valid/ready.
//   out_word carries one PCM frame (first, second, count, last) on
//   valid/ready. cfg_write/cfg_index/cfg_data set sample_format (0),
//   source_channels (1) and dest_channels (2); write them while idle.
//   An accepted word passes in turn through the registered stages input
//   select, round/clip, format shift and output register to out_valid.
//   Throughput: one word per cycle unless out_ready stalls; two lanes
//   convert a frame's two samples side by side; merge builds the output word.
//   A downmix sum is formed one bit wider than the samples.
//   Reset empties the pipeline and loads format 1 (signed 16) with two
//   source and two destination channels.
//   When the receiver stalls, each stage holds until the one after it
//   frees; bubbles are squeezed out, so in_ready drops only once all four
//   stages hold a word.
// ----------------------------------------------------------------------------
module fixed_audio_to_pcm_mixer_unit #(
  parameter int FRAC_BITS = fapcm_pkg::FRAC_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  fapcm_pkg::in_word_t  in_word,
  output logic                 out_valid,
  input  logic                 out_ready,
  output fapcm_pkg::out_word_t out_word,
  input  logic                 cfg_write,
  input  logic [1:0]           cfg_index,
  input  logic [1:0]           cfg_data
);
  import fapcm_pkg::*;

  fmt_t       fmt;
  logic [1:0] src_ch;
  logic [1:0] dst_ch;

  always_ff @(posedge clk) begin
    if (rst) begin
      fmt    <= FMT_S16;
      src_ch <= CH_STEREO;
      dst_ch <= CH_STEREO;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_SAMPLE_FORMAT:   fmt    <= fmt_t'(cfg_data);
        REG_SOURCE_CHANNELS: src_ch <= cfg_data;
        REG_DEST_CHANNELS:   dst_ch <= cfg_data;
        default: ;
      endcase
    end
  end

  // stage 0: channel mode and lane input select
  mode_t                      mode;
  logic signed [SAMPLE_W:0]   mix_sum;
  logic signed [SAMPLE_W-1:0] sel0_next;
  logic signed [SAMPLE_W-1:0] sel1_next;
  logic signed [SAMPLE_W-1:0] sel0;
  logic signed [SAMPLE_W-1:0] sel1;
  ctl_t                       ctl0;
  ctl_t                       ctl1;
  ctl_t                       ctl2;
  logic                       v0;
  logic                       v1;
  logic                       v2;
  logic                       rdy0;
  logic                       rdy1;
  logic                       rdy2;
  logic                       merge_rdy;
  logic [SAMPLE_W-1:0]        pcm0;
  logic [SAMPLE_W-1:0]        pcm1;

  always_comb begin
    if (src_ch == dst_ch) begin
      mode = (src_ch == CH_STEREO) ? MODE_STEREO : MODE_MONO;
    end else if (src_ch < dst_ch) begin
      mode = MODE_UPMIX;
    end else begin
      mode = MODE_DOWNMIX;
    end
    mix_sum   = (SAMPLE_W+1)'(in_word.left_sample) + (SAMPLE_W+1)'(in_word.right_sample);
    sel0_next = (mode == MODE_DOWNMIX) ? SAMPLE_W'(mix_sum >>> 1) : in_word.left_sample;
    sel1_next = (mode == MODE_UPMIX) ? in_word.left_sample : in_word.right_sample;
  end

  // a stage takes a new word when it is empty or its word moves on
  assign rdy2     = !v2 || merge_rdy;
  assign rdy1     = !v1 || rdy2;
  assign rdy0     = !v0 || rdy1;
  assign in_ready = rdy0;

  always_ff @(posedge clk) begin
    if (rst) begin
      v0 <= 1'b0;
      v1 <= 1'b0;
      v2 <= 1'b0;
    end else begin
      if (rdy0) v0 <= in_valid;
      if (rdy1) v1 <= v0;
      if (rdy2) v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy0) begin
      sel0      <= sel0_next;
      sel1      <= sel1_next;
      ctl0.mode <= mode;
      ctl0.last <= in_word.end_of_block;
    end
    if (rdy1) ctl1 <= ctl0;
    if (rdy2) ctl2 <= ctl1;
  end

  fapcm_lane #(.FRAC_BITS(FRAC_BITS)) u_lane0 (
    .clk     (clk),
    .en_clip (rdy1),
    .en_pcm  (rdy2),
    .fmt     (fmt),
    .sample  (sel0),
    .pcm     (pcm0)
  );

  fapcm_lane #(.FRAC_BITS(FRAC_BITS)) u_lane1 (
    .clk     (clk),
    .en_clip (rdy1),
    .en_pcm  (rdy2),
    .fmt     (fmt),
    .sample  (sel1),
    .pcm     (pcm1)
  );

  fapcm_merge u_merge (
    .clk        (clk),
    .rst        (rst),
    .lane_valid (v2),
    .ctl        (ctl2),
    .pcm0       (pcm0),
    .pcm1       (pcm1),
    .lane_ready (merge_rdy),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_word   (out_word)
  );

endmodule

FILE: design/fapcm_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fapcm_checker
// Port-level checks for the PCM converter, bound to the top level.
// ----------------------------------------------------------------------------
module fapcm_checker (
  input logic                 clk,
  input logic                 rst,
  input logic                 in_valid,
  input logic                 in_ready,
  input fapcm_pkg::in_word_t  in_word,
  input logic                 out_valid,
  input logic                 out_ready,
  input fapcm_pkg::out_word_t out_word
);
  import fapcm_pkg::*;

  // pipeline is empty right after reset
  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("out_valid high after reset");

  // a waiting input word stays offered and unchanged
  a_in_hold: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_ready |=> in_valid && $stable(in_word))
    else $error("input word changed while waiting");

  a_hold_valid: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("output word dropped while stalled");

  a_count: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_word.out_count == 2'd1) || (out_word.out_count == 2'd2))
    else $error("bad out_count");

  // single-sample words carry a zero second sample
  a_second_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && (out_word.out_count == 2'd1) |-> (out_word.second_out == '0))
    else $error("second_out not zero for single-sample word");

endmodule

bind fixed_audio_to_pcm_mixer_unit fapcm_checker u_fapcm_checker (.*);

FILE: verif/pcm_frame_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pcm_frame_checker
// Watches the frame and PCM word channels of the mixer together with its
// register port. Every accepted frame is converted on the side with a local
// copy of the format and channel registers. Every accepted PCM word is
// checked field by field against the oldest converted frame still owed.
// ----------------------------------------------------------------------------
module pcm_frame_checker #(
  parameter int FRAC_BITS = fapcm_pkg::FRAC_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  input  logic                 in_ready,
  input  fapcm_pkg::in_word_t  in_word,
  input  logic                 out_valid,
  input  logic                 out_ready,
  input  fapcm_pkg::out_word_t out_word,
  input  logic                 cfg_write,
  input  logic [1:0]           cfg_index,
  input  logic [1:0]           cfg_data,
  output int                   errors,
  output int                   pending
);
  import fapcm_pkg::*;

  localparam longint FULL_SCALE = 64'sd1 <<< FRAC_BITS;

  fmt_t       pcm_format;
  logic [1:0] src_chan_cnt;
  logic [1:0] dst_chan_cnt;
  out_word_t  pcm_words_due[$];

  // round (not s32), clip to [-1.0, +1.0), then scale to the output width
  function automatic logic [31:0] to_pcm(longint sample, fmt_t fmt);
    longint v;
    longint r;
    v = sample;
    case (fmt)
      FMT_U8:  v = v + (64'sd1 <<< (FRAC_BITS - 8));
      FMT_S16: v = v + (64'sd1 <<< (FRAC_BITS - 16));
      FMT_S24: v = v + (64'sd1 <<< (FRAC_BITS - 24));
      default: ;
    endcase
    if (v >= FULL_SCALE) begin
      v = FULL_SCALE - 1;
    end else if (v < -FULL_SCALE) begin
      v = -FULL_SCALE;
    end
    case (fmt)
      FMT_U8:  r = (v >>> (FRAC_BITS - 7)) + 128;
      FMT_S16: r = v >>> (FRAC_BITS - 15);
      FMT_S24: r = v >>> (FRAC_BITS - 23);
      default: r = v <<< (31 - FRAC_BITS);
    endcase
    return r[31:0];
  endfunction

  function automatic out_word_t convert_frame(in_word_t w);
    longint    l;
    longint    r;
    mode_t     mode;
    out_word_t o;
    l = longint'($signed(w.left_sample));
    r = longint'($signed(w.right_sample));
    // channel registers compare as plain numbers, 0 and 3 included
    if (src_chan_cnt == dst_chan_cnt) begin
      mode = (src_chan_cnt == CH_STEREO) ? MODE_STEREO : MODE_MONO;
    end else if (src_chan_cnt < dst_chan_cnt) begin
      mode = MODE_UPMIX;
    end else begin
      mode = MODE_DOWNMIX;
    end
    o = '0;
    o.block_last = w.end_of_block;
    case (mode)
      MODE_STEREO: begin
        o.first_out  = to_pcm(l, pcm_format);
        o.second_out = to_pcm(r, pcm_format);
        o.out_count  = 2'd2;
      end
      MODE_MONO: begin
        o.first_out = to_pcm(l, pcm_format);
        o.out_count = 2'd1;
      end
      MODE_UPMIX: begin
        o.first_out  = to_pcm(l, pcm_format);
        o.second_out = o.first_out;
        o.out_count  = 2'd2;
      end
      default: begin
        // 64-bit sum, no wrap
        o.first_out = to_pcm((l + r) >>> 1, pcm_format);
        o.out_count = 2'd1;
      end
    endcase
    return o;
  endfunction

  task automatic check_field(string field, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      $error("%s: expected %h, actual %h", field, want, got);
      errors++;
    end
  endtask

  always @(posedge clk) begin
    out_word_t due;
    if (rst) begin
      pcm_format   <= FMT_S16;
      src_chan_cnt <= CH_STEREO;
      dst_chan_cnt <= CH_STEREO;
      pcm_words_due.delete();
      pending      <= 0;
    end else begin
      if (out_valid && out_ready) begin
        if (pcm_words_due.size() == 0) begin
          $error("pcm word with none expected: %h", out_word);
          errors++;
        end else begin
          due = pcm_words_due.pop_front();
          check_field("first_out", due.first_out, out_word.first_out);
          check_field("second_out", due.second_out, out_word.second_out);
          check_field("out_count", 32'(due.out_count), 32'(out_word.out_count));
          check_field("block_last", 32'(due.block_last), 32'(out_word.block_last));
        end
      end
      if (in_valid && in_ready) begin
        pcm_words_due.push_back(convert_frame(in_word));
      end
      if (cfg_write) begin
        case (cfg_index)
          REG_SAMPLE_FORMAT:   pcm_format   <= fmt_t'(cfg_data);
          REG_SOURCE_CHANNELS: src_chan_cnt <= cfg_data;
          REG_DEST_CHANNELS:   dst_chan_cnt <= cfg_data;
          default: ;
        endcase
      end
      pending <= pcm_words_due.size();
    end
  end

endmodule

FILE: verif/tb_fixed_audio_to_pcm_mixer_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_fixed_audio_to_pcm_mixer_unit
// Drives fixed-point stereo frames into the PCM mixer under every sample
// format and channel mode, with random gaps on both sides and one long
// receiver stall. The frame checker beside the block does the comparison.
// ----------------------------------------------------------------------------
module tb_fixed_audio_to_pcm_mixer_unit;
  import fapcm_pkg::*;

  localparam int     F           = FRAC_BITS_DEF;
  localparam longint ONE         = 64'sd1 <<< F;
  localparam int     HOLD_CYCLES = 200;
  localparam int     PHASES      = 20;
  localparam int     PHASE_WORDS = 50;

  logic       clk;
  logic       rst       = 1'b1;
  logic       in_valid  = 1'b0;
  logic       in_ready;
  in_word_t   in_word   = '0;
  logic       out_valid;
  logic       out_ready = 1'b0;
  out_word_t  out_word;
  logic       cfg_write = 1'b0;
  logic [1:0] cfg_index = REG_SAMPLE_FORMAT;
  logic [1:0] cfg_data  = 2'd0;

  int errors;
  int pending;

  bit tx_steady        = 1'b0;
  bit rx_steady        = 1'b0;
  bit hold_off_request = 1'b0;

  fixed_audio_to_pcm_mixer_unit #(.FRAC_BITS(F)) dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_word   (in_word),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_word  (out_word),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  pcm_frame_checker #(.FRAC_BITS(F)) u_frame_checker (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_word   (in_word),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_word  (out_word),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .errors    (errors),
    .pending   (pending)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("== FAIL ==");
    $finish;
  end

  // sample values biased toward clip and rounding edges
  function automatic logic [31:0] pick_sample();
    longint v;
    int     k;
    k = int'($urandom_range(F - 8, F - 24));
    case ($urandom_range(0, 7))
      0: v = longint'($urandom);
      1: begin
        case ($urandom_range(0, 4))
          0: v = 64'sd2147483647;
          1: v = -64'sd2147483648;
          2: v = 0;
          3: v = 1;
          default: v = -1;
        endcase
      end
      2: v = ONE - (64'sd1 <<< k) + longint'(int'($urandom_range(0, 2))) - 1;
      3: v = -ONE + longint'(int'($urandom_range(0, 2))) - 1;
      4: begin
        // half an output lsb, either side of zero
        v = (64'sd1 <<< k) + longint'(int'($urandom_range(0, 2))) - 1;
        if ($urandom_range(0, 1) == 1) begin
          v = -v;
        end
      end
      7: v = longint'(int'($urandom_range(0, 255))) - 128;
      default: v = longint'($urandom & 32'(2 * ONE - 1)) - ONE;
    endcase
    return v[31:0];
  endfunction

  task automatic send_pair(logic [31:0] l, logic [31:0] r, logic last);
    in_word_t w;
    w.left_sample  = l;
    w.right_sample = r;
    w.end_of_block = last;
    if (!tx_steady && $urandom_range(0, 99) < 30) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(0, 99) < 30);
    end
    in_valid <= 1'b1;
    in_word  <= w;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic write_reg(logic [1:0] index, logic [1:0] value);
    cfg_write <= 1'b1;
    cfg_index <= index;
    cfg_data  <= value;
    @(posedge clk);
  endtask

  // registers change only once every word in flight has come out
  task automatic set_config(fmt_t fmt, logic [1:0] src, logic [1:0] dst);
    in_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    write_reg(REG_SAMPLE_FORMAT, fmt);
    write_reg(REG_SOURCE_CHANNELS, src);
    write_reg(REG_DEST_CHANNELS, dst);
    cfg_write <= 1'b0;
  endtask

  // receiver: random back-pressure plus one long hold-off on request
  initial begin
    forever begin
      @(posedge clk);
      if (hold_off_request) begin
        hold_off_request = 1'b0;
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end
      out_ready <= rx_steady || ($urandom_range(0, 99) >= 30);
    end
  end

  initial begin
    fmt_t       fmt;
    logic [1:0] src;
    logic [1:0] dst;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset setting: signed 16, stereo copy
    send_pair(32'h7FFF_FFFF, 32'h8000_0000, 1'b0);
    send_pair(32'h0000_0000, 32'hFFFF_FFFF, 1'b1);
    send_pair(32'(ONE - 1), 32'(-ONE), 1'b0);
    send_pair(32'(ONE), 32'(-ONE - 1), 1'b0);
    send_pair(32'(ONE - (64'sd1 <<< (F - 16))), 32'(ONE - (64'sd1 <<< (F - 16)) - 1), 1'b0);
    send_pair(32'((64'sd1 <<< (F - 16)) - 1), 32'(64'sd1 <<< (F - 16)), 1'b0);
    send_pair(32'(-(64'sd1 <<< (F - 16))), 32'(-(64'sd1 <<< (F - 16)) - 1), 1'b1);
    send_pair(32'h5555_5555, 32'hAAAA_AAAA, 1'b0);
    send_pair(32'hAAAA_AAAA, 32'h5555_5555, 1'b1);

    // downmix at full 32 bit: sums past the sample range
    set_config(FMT_S32, CH_STEREO, CH_MONO);
    send_pair(32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b0);
    send_pair(32'h8000_0000, 32'h8000_0000, 1'b1);
    send_pair(32'h7FFF_FFFF, 32'h8000_0000, 1'b0);
    send_pair(32'(ONE - 1), 32'(ONE - 1), 1'b0);
    send_pair(32'(-ONE), 32'(-ONE - 1), 1'b1);

    // mono copy to unsigned 8: second sample must read zero
    set_config(FMT_U8, CH_MONO, CH_MONO);
    send_pair(32'h7FFF_FFFF, 32'h1234_5678, 1'b0);
    send_pair(32'h8000_0000, 32'h7FFF_FFFF, 1'b1);
    send_pair(32'((64'sd1 <<< (F - 8)) - 1), 32'h0, 1'b0);

    for (int p = 0; p < PHASES; p++) begin
      fmt = fmt_t'(p % 4);
      case (p / 4)
        0: begin src = CH_STEREO; dst = CH_STEREO; end
        1: begin src = CH_MONO;   dst = CH_MONO;   end
        2: begin src = CH_MONO;   dst = CH_STEREO; end
        3: begin src = CH_STEREO; dst = CH_MONO;   end
        default: begin
          // channel counts outside 1..2
          case (p % 4)
            0: begin src = 2'd3; dst = 2'd3; end
            1: begin src = 2'd0; dst = 2'd0; end
            2: begin src = 2'd0; dst = 2'd3; end
            default: begin src = 2'd3; dst = 2'd0; end
          endcase
        end
      endcase
      set_config(fmt, src, dst);
      tx_steady = (p == 7) || (p == 10) || (p == 11);
      rx_steady = (p == 10) || (p == 11);
      // long receiver stall while frames keep coming: fills the pipeline
      if (p == 7) begin
        hold_off_request = 1'b1;
      end
      repeat (PHASE_WORDS) begin
        send_pair(pick_sample(), pick_sample(), 1'($urandom_range(0, 1)));
      end
    end

    in_valid <= 1'b0;
    tx_steady = 1'b1;
    rx_steady = 1'b1;
    do @(posedge clk); while (pending != 0);
    repeat (20) @(posedge clk);
    if (errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

FILE: fixed_audio_to_pcm_mixer_unit.f
design/fapcm_pkg.sv
design/fapcm_lane.sv
design/fapcm_merge.sv
design/fixed_audio_to_pcm_mixer_unit.sv
design/fapcm_checker.sv
verif/pcm_frame_checker.sv
verif/tb_fixed_audio_to_pcm_mixer_unit.sv
